// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GOS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GOS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/gos_pkg.sv =====
package gos_pkg;

   localparam int MAX_LIST_DEF    = 64;
   localparam int LABEL_WIDTH_DEF = 16;

   localparam int KIND_WIDTH  = 3;
   localparam int VALUE_WIDTH = 16;
   localparam int SCORE_WIDTH = 17;
   localparam int COUNT_WIDTH = 7;
   localparam int FRAC_BITS   = 16;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [KIND_WIDTH-1:0] KIND_NODE_A  = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_NODE_B  = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_EDGE_A  = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_EDGE_B  = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_COMPUTE = 3'd4;

   localparam logic [SCORE_WIDTH-1:0] THRESH_RESET = 17'd52429;

   typedef struct packed {
      logic                   is_compute;
      logic [1:0]             list_sel;
      logic [VALUE_WIDTH-1:0] value;
   } q_word_type;

   typedef struct packed {
      logic       valid;
      q_word_type word;
   } q_push_type;

   typedef struct packed {
      logic       valid;
      q_word_type word;
   } q_pop_type;

endpackage

// ===== src/gos_channel_if.sv =====
interface gos_req_if;
   import gos_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [KIND_WIDTH-1:0]  kind;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, output kind, output value, input ready);
   modport sink (input valid, input kind, input value, output ready);
endinterface

interface gos_rsp_if;
   import gos_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [SCORE_WIDTH-1:0] score;
   logic                   is_similar;
   logic [COUNT_WIDTH-1:0] common_node_count;
   logic [COUNT_WIDTH-1:0] common_edge_count;
   logic                   overflowed;

   modport source (output valid, output score, output is_similar,
                   output common_node_count, output common_edge_count,
                   output overflowed, input ready);
   modport sink (input valid, input score, input is_similar,
                 input common_node_count, input common_edge_count,
                 input overflowed, output ready);
endinterface

// ===== src/gos_ram.sv =====
module gos_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== src/gos_front.sv =====
module gos_front (
   gos_req_if.sink            req_chan,
   input  logic               q_full,
   output gos_pkg::q_push_type push
);
   import gos_pkg::*;

   logic       keep;
   logic       is_compute;
   logic [1:0] list_sel;

   always_comb begin
      keep       = 1'b1;
      is_compute = 1'b0;
      list_sel   = req_chan.kind[1:0];
      case (req_chan.kind)
         KIND_NODE_A, KIND_NODE_B, KIND_EDGE_A, KIND_EDGE_B: begin
            keep = 1'b1;
         end
         KIND_COMPUTE: begin
            is_compute = 1'b1;
            list_sel   = 2'd0;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_chan.ready       = !q_full;
   assign push.valid           = req_chan.valid && !q_full && keep;
   assign push.word.is_compute = is_compute;
   assign push.word.list_sel   = list_sel;
   assign push.word.value      = req_chan.value;
endmodule

// ===== src/gos_queue.sv =====
module gos_queue (
   input  logic                clock,
   input  logic                reset,
   input  gos_pkg::q_push_type push,
   input  logic                pop_en,
   output logic                full,
   output gos_pkg::q_pop_type  pop
);
   import gos_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   q_word_type    mem_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign full    = (count_ff == CW'(QUEUE_DEPTH));
   assign do_push = push.valid && !full;
   assign do_pop  = pop_en && (count_ff != '0);

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.word;
      end
   end

   assign pop.valid = (count_ff != '0);
   assign pop.word  = mem_ff[rd_ptr_ff];
endmodule

// ===== src/gos_back.sv =====
module gos_back #(
   parameter int MAX_LIST    = gos_pkg::MAX_LIST_DEF,
   parameter int LABEL_WIDTH = gos_pkg::LABEL_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  gos_pkg::q_pop_type              pop,
   output logic                            pop_en,
   input  logic [gos_pkg::SCORE_WIDTH-1:0] thresh,
   gos_rsp_if.source                       rsp_chan
);
   import gos_pkg::*;

   localparam int IW = $clog2(MAX_LIST);
   localparam int LW = $clog2(MAX_LIST + 1);
   localparam int TW = $clog2(4 * MAX_LIST + 1);
   localparam int MW = $clog2(2 * MAX_LIST + 1);
   localparam int DW = TW + SCORE_WIDTH;
   localparam int VW = (LABEL_WIDTH > VALUE_WIDTH) ? LABEL_WIDTH : VALUE_WIDTH;
   localparam int CW = (LW > COUNT_WIDTH) ? LW : COUNT_WIDTH;
   localparam int SW = $clog2(SCORE_WIDTH + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_CMP  = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [LW-1:0]          len_ff [4];
   logic [LW-1:0]          len_in [4];
   logic [LW-1:0]          idx_ff [4];
   logic [LW-1:0]          idx_in [4];
   logic [LW-1:0]          match_ff [2];
   logic [LW-1:0]          match_in [2];
   logic [TW-1:0]          total_ff, total_in;
   logic [TW-1:0]          rem_ff, rem_in;
   logic [SCORE_WIDTH-1:0] quo_ff, quo_in;
   logic [SW-1:0]          step_ff, step_in;
   logic                   overflow_ff, overflow_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SCORE_WIDTH-1:0] score_ff, score_in;
   logic                   sim_ff, sim_in;
   logic [COUNT_WIDTH-1:0] cn_ff, cn_in;
   logic [COUNT_WIDTH-1:0] ce_ff, ce_in;
   logic                   ovf_out_ff, ovf_out_in;

   logic [3:0]             wr_en;
   logic [LABEL_WIDTH-1:0] rd_data [4];
   logic [VW-1:0]          value_w;
   logic [LABEL_WIDTH-1:0] wr_label;
   logic [LW-1:0]          sel_len;
   logic [1:0]             active;
   logic                   walk_done;
   logic [MW-1:0]          match_sum;
   logic [DW-1:0]          dividend;
   logic [CW-1:0]          cn_w;
   logic [CW-1:0]          ce_w;

   assign value_w   = VW'(pop.word.value);
   assign wr_label  = value_w[LABEL_WIDTH-1:0];
   assign sel_len   = len_ff[pop.word.list_sel];
   assign active[0] = (idx_ff[0] < len_ff[0]) && (idx_ff[1] < len_ff[1]);
   assign active[1] = (idx_ff[2] < len_ff[2]) && (idx_ff[3] < len_ff[3]);
   assign walk_done = !active[0] && !active[1];
   assign match_sum = MW'(match_ff[0]) + MW'(match_ff[1]);
   assign dividend  = (DW'(match_sum) << (FRAC_BITS + 1)) + DW'(total_ff >> 1);
   assign cn_w      = CW'(match_ff[0]);
   assign ce_w      = CW'(match_ff[1]);

   for (genvar g = 0; g < 4; g++) begin : g_list
      gos_ram #(
         .WIDTH (LABEL_WIDTH),
         .DEPTH (MAX_LIST)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en[g]),
         .wr_addr (sel_len[IW-1:0]),
         .wr_data (wr_label),
         .rd_addr (idx_ff[g][IW-1:0]),
         .rd_data (rd_data[g])
      );
   end

   always_comb begin
      logic [TW:0] rs;
      logic        qbit;
      rs           = {rem_ff, quo_ff[SCORE_WIDTH-1]};
      qbit         = 1'b0;
      state_in     = state_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      match_in     = match_ff;
      total_in     = total_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      score_in     = score_ff;
      sim_in       = sim_ff;
      cn_in        = cn_ff;
      ce_in        = ce_ff;
      ovf_out_in   = ovf_out_ff;
      wr_en        = '0;
      pop_en       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (pop.valid) begin
               pop_en = 1'b1;
               if (pop.word.is_compute) begin
                  for (int k = 0; k < 4; k++) begin
                     idx_in[k] = '0;
                  end
                  match_in[0] = '0;
                  match_in[1] = '0;
                  total_in    = TW'(len_ff[0]) + TW'(len_ff[1])
                              + TW'(len_ff[2]) + TW'(len_ff[3]);
                  state_in    = S_READ;
               end else if (sel_len == LW'(MAX_LIST)) begin
                  overflow_in = 1'b1;
               end else begin
                  wr_en[pop.word.list_sel]  = 1'b1;
                  len_in[pop.word.list_sel] = sel_len + 1'b1;
               end
            end
         end
         S_READ: begin
            if (!walk_done) begin
               state_in = S_CMP;
            end else if (total_ff == '0) begin
               quo_in   = '0;
               state_in = S_OUT;
            end else begin
               rem_in   = dividend[DW-1:SCORE_WIDTH];
               quo_in   = dividend[SCORE_WIDTH-1:0];
               step_in  = '0;
               state_in = S_DIV;
            end
         end
         S_CMP: begin
            for (int p = 0; p < 2; p++) begin
               if (active[p]) begin
                  if (rd_data[2*p] == rd_data[2*p+1]) begin
                     match_in[p]   = match_ff[p] + 1'b1;
                     idx_in[2*p]   = idx_ff[2*p] + 1'b1;
                     idx_in[2*p+1] = idx_ff[2*p+1] + 1'b1;
                  end else if (rd_data[2*p] < rd_data[2*p+1]) begin
                     idx_in[2*p] = idx_ff[2*p] + 1'b1;
                  end else begin
                     idx_in[2*p+1] = idx_ff[2*p+1] + 1'b1;
                  end
               end
            end
            state_in = S_READ;
         end
         S_DIV: begin
            if (rs >= {1'b0, total_ff}) begin
               rem_in = TW'(rs - {1'b0, total_ff});
               qbit   = 1'b1;
            end else begin
               rem_in = rs[TW-1:0];
            end
            quo_in  = {quo_ff[SCORE_WIDTH-2:0], qbit};
            step_in = step_ff + 1'b1;
            if (step_ff == SW'(SCORE_WIDTH - 1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               score_in     = quo_ff;
               sim_in       = (quo_ff >= thresh);
               cn_in        = cn_w[COUNT_WIDTH-1:0];
               ce_in        = ce_w[COUNT_WIDTH-1:0];
               ovf_out_in   = overflow_ff;
               for (int k = 0; k < 4; k++) begin
                  len_in[k] = '0;
               end
               overflow_in  = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 4; k++) begin
            len_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      match_ff   <= match_in;
      total_ff   <= total_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      step_ff    <= step_in;
      score_ff   <= score_in;
      sim_ff     <= sim_in;
      cn_ff      <= cn_in;
      ce_ff      <= ce_in;
      ovf_out_ff <= ovf_out_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.score             = score_ff;
   assign rsp_chan.is_similar        = sim_ff;
   assign rsp_chan.common_node_count = cn_ff;
   assign rsp_chan.common_edge_count = ce_ff;
   assign rsp_chan.overflowed        = ovf_out_ff;
endmodule

// ===== src/graph_overlap_similarity_top.sv =====
// Load word: accepted when the queue has room; written to its list when the back pops it.
// Compute word: the back alternates read and compare for s merge steps, then divides, with
//   all lists empty skipping the division; s <= max(nodeA+nodeB, edgeA+edgeB) - 1.
// Throughput: 1 load word per cycle while the 4-deep queue has room; back holds one compute.
// Synchronous active-high reset clears lengths, overflow, queue and output valid;
//   threshold resets to 0.8 in Q1.16. No clearing pass over the list memories.
module graph_overlap_similarity_top #(
   parameter int MAX_LIST    = gos_pkg::MAX_LIST_DEF,
   parameter int LABEL_WIDTH = gos_pkg::LABEL_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   gos_req_if.sink                         req_chan,
   gos_rsp_if.source                       rsp_chan,
   input  logic                            csr_wr_en,
   input  logic [gos_pkg::SCORE_WIDTH-1:0] csr_wr_data
);
   import gos_pkg::*;

   logic [SCORE_WIDTH-1:0] thresh_ff, thresh_in;
   q_push_type             push;
   q_pop_type              pop;
   logic                   q_full;
   logic                   pop_en;

   assign thresh_in = csr_wr_en ? csr_wr_data : thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   gos_front u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .push     (push)
   );

   gos_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .pop_en (pop_en),
      .full   (q_full),
      .pop    (pop)
   );

   gos_back #(
      .MAX_LIST    (MAX_LIST),
      .LABEL_WIDTH (LABEL_WIDTH)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .pop      (pop),
      .pop_en   (pop_en),
      .thresh   (thresh_ff),
      .rsp_chan (rsp_chan)
   );
endmodule

// ===== src/gos_checker.sv =====
`include "assert_macros.svh"

module gos_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [gos_pkg::SCORE_WIDTH-1:0] score,
   input logic                            is_similar,
   input logic                            csr_wr_en,
   input logic [gos_pkg::SCORE_WIDTH-1:0] csr_wr_data
);
   import gos_pkg::*;

   logic [SCORE_WIDTH-1:0] thresh_ff, thresh_in;

   assign thresh_in = csr_wr_en ? csr_wr_data : thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   `GOS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(score) && $stable(is_similar), "rsp word changed while stalled")
   `GOS_ASSERT_NOW(a_score_range, clock, reset, rsp_valid, score <= 17'd65536, "score above 1.0")
   `GOS_ASSERT_NOW(a_similar, clock, reset, rsp_valid, is_similar == (score >= thresh_ff), "is_similar disagrees with threshold")
   `GOS_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid, "rsp valid right after reset")
endmodule

bind graph_overlap_similarity_top gos_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .score       (rsp_chan.score),
   .is_similar  (rsp_chan.is_similar),
   .csr_wr_en   (csr_wr_en),
   .csr_wr_data (csr_wr_data)
);
